// ===== hw/rtl/xbr_pkg.sv =====
package xbr_pkg;

  // Generator word and wide-value widths
  localparam int WORD_BITS = 32;
  localparam int WIDE_BITS = 64;
  localparam int CNT_BITS  = $clog2(WIDE_BITS);

  // xorshift shift amounts
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  // State after reset, also taken when a zero seed is written
  localparam logic [WORD_BITS-1:0] DEFAULT_SEED = 32'd2463534242;

  // Configuration port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_SEED = 1'b0;

  // Request selector codes
  localparam logic [2:0] FUNC_RAW32   = 3'd0;
  localparam logic [2:0] FUNC_MOD32   = 3'd1;
  localparam logic [2:0] FUNC_RANGE32 = 3'd2;
  localparam logic [2:0] FUNC_RAW64   = 3'd3;
  localparam logic [2:0] FUNC_MOD64   = 3'd4;
  localparam logic [2:0] FUNC_RANGE64 = 3'd5;
  localparam logic [2:0] FUNC_BYTE    = 3'd6;
  localparam logic [2:0] FUNC_BIT     = 3'd7;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/xbr_if.sv =====
// Request channel: selector and bounds
interface xbr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] lower_bound;
  logic [63:0] upper_bound;

  modport source (output valid, output func, output lower_bound, output upper_bound,
                  input ready);
  modport sink (input valid, input func, input lower_bound, input upper_bound,
                output ready);
endinterface

// Result channel: generated value and divide error
interface xbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;
  logic        divide_error;

  modport source (output valid, output random_value, output divide_error, input ready);
  modport sink (input valid, input random_value, input divide_error, output ready);
endinterface

// ===== hw/rtl/xbr_xorshift.sv =====
module xbr_xorshift (
  input  logic [xbr_pkg::WORD_BITS-1:0] state_cur,
  output logic [xbr_pkg::WORD_BITS-1:0] state_adv
);
  import xbr_pkg::*;

  logic [WORD_BITS-1:0] s1;
  logic [WORD_BITS-1:0] s2;

  // Apply the three xor-shift steps
  always_comb begin
    s1        = state_cur ^ (state_cur << SHIFT_A);
    s2        = s1 ^ (s1 >> SHIFT_B);
    state_adv = s2 ^ (s2 << SHIFT_C);
  end

endmodule

// ===== hw/rtl/xbr_divider.sv =====
module xbr_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [xbr_pkg::WIDE_BITS-1:0] dividend,
  input  logic [xbr_pkg::WIDE_BITS-1:0] divisor,
  output logic [xbr_pkg::WIDE_BITS-1:0] remainder,
  output xbr_pkg::div_stat_t            stat
);
  import xbr_pkg::*;

  logic [WIDE_BITS-1:0] rem;
  logic [WIDE_BITS-1:0] rem_next;
  logic [WIDE_BITS-1:0] dq;
  logic [WIDE_BITS-1:0] dv;
  logic [CNT_BITS-1:0]  count;
  logic                 busy;
  logic                 done;
  logic [WIDE_BITS:0]   trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, dq[WIDE_BITS-1]};
    if (trial >= {1'b0, dv}) begin
      rem_next = WIDE_BITS'(trial - {1'b0, dv});
    end else begin
      rem_next = trial[WIDE_BITS-1:0];
    end
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_BITS'(WIDE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands on start, advance one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[WIDE_BITS-2:0], 1'b0};
    end
  end

  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/xorshift_bounded_rng.sv =====
// xorshift_bounded_rng: 32-bit xorshift generator (shifts 13, 17, 5) that returns one value
// per request on the req/rsp channels. func selects raw32, mod32, range32, raw64, mod64,
// range64, byte or bit; the 64-bit forms take two advances, first word low. A range maps
// x to (x mod (upper-lower)) + lower, wrapped at the form's width; a zero modulus or width
// returns 0 with divide_error set. Requests are taken one at a time. After the accept, the
// sequencer advances the generator in ADV_LO (and ADV_HI for the 64-bit forms); the mod
// and range forms then go through START and WAIT on the one-bit-a-cycle 64-step shared
// divider, and a zero modulus or width skips the divider from START. The result is then
// loaded into the output register once the slot is free. The next request is accepted
// from the cycle after the result is loaded. A finished result waits in the output
// register while the next request is accepted. The seed register sits at address 0 of
// the APB port; writing it reloads the state, and a zero seed loads the default 2463534242.
module xorshift_bounded_rng (
  input  logic                          clk,
  input  logic                          rst,
  xbr_req_if.sink                       req,
  xbr_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xbr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [xbr_pkg::DATA_BITS-1:0] pwdata,
  output logic [xbr_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import xbr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ADV_LO = 5'b00010,
    ST_ADV_HI = 5'b00100,
    ST_START  = 5'b01000,
    ST_WAIT   = 5'b10000
  } seq_state_t;

  seq_state_t           state;
  logic                 pend;
  logic [WORD_BITS-1:0] seed_value;
  logic [WORD_BITS-1:0] gen_state;
  logic [WORD_BITS-1:0] gen_adv;
  logic [WORD_BITS-1:0] word_lo;
  logic [WORD_BITS-1:0] word_hi;
  logic [2:0]           func_q;
  logic [WIDE_BITS-1:0] lo_q;
  logic [WIDE_BITS-1:0] hi_q;
  logic                 err_q;
  logic [WIDE_BITS-1:0] dividend;
  logic [WIDE_BITS-1:0] divisor;
  logic [WIDE_BITS-1:0] remainder;
  logic [WIDE_BITS-1:0] value_next;
  logic [WORD_BITS-1:0] sum32;
  logic                 div_start;
  div_stat_t            div_stat;
  logic                 is_wide;
  logic                 is_div;
  logic                 cfg_write;
  logic                 out_valid;
  logic                 out_free;

  xbr_xorshift u_step (
    .state_cur (gen_state),
    .state_adv (gen_adv)
  );

  xbr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .remainder (remainder),
    .stat      (div_stat)
  );

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SEED);
  assign prdata    = (paddr[2] == REG_SEED) ? seed_value : '0;

  // Decode the latched selector
  assign is_wide = (func_q == FUNC_RAW64) || (func_q == FUNC_MOD64) ||
                   (func_q == FUNC_RANGE64);
  assign is_div  = (func_q == FUNC_MOD32) || (func_q == FUNC_RANGE32) ||
                   (func_q == FUNC_MOD64) || (func_q == FUNC_RANGE64);

  // Divisor and dividend for the mod and range forms
  always_comb begin
    case (func_q)
      FUNC_MOD32:   divisor = {{(WIDE_BITS-WORD_BITS){1'b0}}, hi_q[WORD_BITS-1:0]};
      FUNC_RANGE32: divisor = {{(WIDE_BITS-WORD_BITS){1'b0}},
                               WORD_BITS'(hi_q[WORD_BITS-1:0] - lo_q[WORD_BITS-1:0])};
      FUNC_MOD64:   divisor = hi_q;
      FUNC_RANGE64: divisor = hi_q - lo_q;
      default:      divisor = '0;
    endcase
    if (is_wide) begin
      dividend = {word_hi, word_lo};
    end else begin
      dividend = {{(WIDE_BITS-WORD_BITS){1'b0}}, word_lo};
    end
  end

  assign div_start = (state == ST_START) && (divisor != '0);

  // Shape the final value
  assign sum32 = remainder[WORD_BITS-1:0] + lo_q[WORD_BITS-1:0];
  always_comb begin
    case (func_q)
      FUNC_RAW32:   value_next = {{(WIDE_BITS-WORD_BITS){1'b0}}, word_lo};
      FUNC_MOD32:   value_next = {{(WIDE_BITS-WORD_BITS){1'b0}},
                                  remainder[WORD_BITS-1:0]};
      FUNC_RANGE32: value_next = {{(WIDE_BITS-WORD_BITS){1'b0}}, sum32};
      FUNC_RAW64:   value_next = {word_hi, word_lo};
      FUNC_MOD64:   value_next = remainder;
      FUNC_RANGE64: value_next = remainder + lo_q;
      FUNC_BYTE:    value_next = {{(WIDE_BITS-8){1'b0}}, word_lo[7:0]};
      default:      value_next = {{(WIDE_BITS-1){1'b0}}, word_lo[0]};
    endcase
    if (err_q) begin
      value_next = '0;
    end
  end

  // Output slot is free when empty or being taken this cycle
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && !pend;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pend) begin
            if (out_free) begin
              pend <= 1'b0;
            end
          end else if (req.valid) begin
            state <= ST_ADV_LO;
          end
        end
        ST_ADV_LO: begin
          if (is_wide) begin
            state <= ST_ADV_HI;
          end else if (is_div) begin
            state <= ST_START;
          end else begin
            state <= ST_IDLE;
            pend  <= 1'b1;
          end
        end
        ST_ADV_HI: begin
          if (is_div) begin
            state <= ST_START;
          end else begin
            state <= ST_IDLE;
            pend  <= 1'b1;
          end
        end
        ST_START: begin
          if (divisor == '0) begin
            state <= ST_IDLE;
            pend  <= 1'b1;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_stat.done && !div_stat.busy) begin
            state <= ST_IDLE;
            pend  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch the request and clear the error flag on accept
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func_q <= req.func;
      lo_q   <= req.lower_bound;
      hi_q   <= req.upper_bound;
      err_q  <= 1'b0;
    end else if ((state == ST_START) && (divisor == '0)) begin
      err_q <= 1'b1;
    end
  end

  // Seed register and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= DEFAULT_SEED;
      gen_state  <= DEFAULT_SEED;
    end else if (cfg_write) begin
      seed_value <= pwdata[WORD_BITS-1:0];
      gen_state  <= (pwdata[WORD_BITS-1:0] != '0) ? pwdata[WORD_BITS-1:0] : DEFAULT_SEED;
    end else if ((state == ST_ADV_LO) || (state == ST_ADV_HI)) begin
      gen_state <= gen_adv;
    end
  end

  // Capture the advanced words
  always_ff @(posedge clk) begin
    if (state == ST_ADV_LO) begin
      word_lo <= gen_adv;
    end
    if (state == ST_ADV_HI) begin
      word_hi <= gen_adv;
    end
  end

  // Output register: load when a pending result finds the slot free, else drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_IDLE) && pend && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && pend && out_free) begin
      rsp.random_value <= value_next;
      rsp.divide_error <= err_q;
    end
  end

  assign rsp.valid = out_valid;

endmodule
